### sv/srht_pkg.sv
`timescale 1ns / 1ps

package srht_pkg;

  // Request codes carried in the req_type field of an input item.
  localparam logic [1:0] REQ_PROBE  = 2'd0;
  localparam logic [1:0] REQ_STORE  = 2'd1;
  localparam logic [1:0] REQ_NEWGEN = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  // Bound kinds kept with each slot.
  localparam logic [1:0] FLAG_NONE  = 2'd0;
  localparam logic [1:0] FLAG_EXACT = 2'd1;
  localparam logic [1:0] FLAG_LOWER = 2'd2;
  localparam logic [1:0] FLAG_UPPER = 2'd3;

  // Marker for "no square".
  localparam logic signed [7:0] NO_SQUARE = -8'sd1;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [63:0]         pos_key;
    logic signed [15:0]  depth_left;
    logic signed [31:0]  window_low;
    logic signed [31:0]  window_high;
    logic signed [31:0]  score_in;
    logic [1:0]          bound_kind;
    logic signed [7:0]   from_in;
    logic signed [7:0]   to_in;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic               key_match;
    logic signed [31:0] score_out;
    logic signed [7:0]  from_out;
    logic signed [7:0]  to_out;
    logic               written;
  } out_item_t;

  // One table slot as it sits in memory.
  typedef struct packed {
    logic [63:0]        key;
    logic signed [31:0] score;
    logic signed [7:0]  to_sq;
    logic signed [7:0]  from_sq;
    logic [7:0]         gen;
    logic [1:0]         flag;
    logic signed [15:0] depth;
  } slot_t;

  localparam slot_t CLEARED_SLOT = '{
    key:     64'd0,
    score:   32'sd0,
    to_sq:   NO_SQUARE,
    from_sq: NO_SQUARE,
    gen:     8'd0,
    flag:    FLAG_NONE,
    depth:   16'sd0
  };

  localparam out_item_t OUT_DEFAULT = '{
    hit:       1'b0,
    key_match: 1'b0,
    score_out: 32'sd0,
    from_out:  NO_SQUARE,
    to_out:    NO_SQUARE,
    written:   1'b0
  };

endpackage

### sv/srht_ram.sv
`timescale 1ns / 1ps

module srht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single port, registered read (old data on a write cycle).
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

### sv/search_result_hash_table.sv
`timescale 1ns / 1ps
// Probe, store and new-search items: the slot is read on acceptance, compared in the
// lookup state and the result registered from there; busy is high for one cycle and no
// item is taken while busy. Clear item: one memory write per slot, busy until the last
// slot is written, result in the next cycle. The single-port slot memory allows one read
// or one write per cycle. After synchronous reset the block is busy clearing the table.
// Results are strobed for one cycle; the receiver cannot stall them.

module search_result_hash_table
  import srht_pkg::*;
#(
  parameter int INDEX_BITS = 10
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int SLOTS = 1 << INDEX_BITS;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_LOOKUP = 3'b010,
    ST_CLEAR  = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic [INDEX_BITS-1:0] clr_cnt_r, clr_cnt_nxt;
  logic                  clr_report_r, clr_report_nxt;
  logic [7:0]            gen_r, gen_nxt;
  in_item_t              req_r;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r, out_item_nxt;

  logic                  ram_we;
  logic [INDEX_BITS-1:0] ram_addr;
  slot_t                 ram_wdata;
  slot_t                 ram_rdata;

  logic accept;
  logic key_eq, depth_ok, bound_ok, keep;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  srht_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Compare the slot read for the held item.
  assign key_eq   = (ram_rdata.key == req_r.pos_key);
  assign depth_ok = (ram_rdata.depth >= req_r.depth_left);
  always_comb begin
    case (ram_rdata.flag)
      FLAG_EXACT: bound_ok = 1'b1;
      FLAG_LOWER: bound_ok = (ram_rdata.score >= req_r.window_high);
      FLAG_UPPER: bound_ok = (ram_rdata.score <= req_r.window_low);
      default:    bound_ok = 1'b0;
    endcase
  end
  // A store keeps a deeper entry of the same position from this search.
  assign keep = key_eq && (ram_rdata.gen == gen_r) && (ram_rdata.depth > req_r.depth_left);

  // Control, memory access and result formation.
  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    clr_report_nxt = clr_report_r;
    gen_nxt        = gen_r;
    out_valid_nxt  = 1'b0;
    out_item_nxt   = OUT_DEFAULT;
    ram_we         = 1'b0;
    ram_addr       = in_item.pos_key[INDEX_BITS-1:0];
    ram_wdata      = CLEARED_SLOT;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_item.req_type == REQ_CLEAR) begin
            state_nxt      = ST_CLEAR;
            clr_cnt_nxt    = '0;
            clr_report_nxt = 1'b1;
            gen_nxt        = 8'd0;
          end else begin
            state_nxt = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        ram_addr      = req_r.pos_key[INDEX_BITS-1:0];
        case (req_r.req_type)
          REQ_PROBE: begin
            if (key_eq) begin
              out_item_nxt.key_match = 1'b1;
              out_item_nxt.from_out  = ram_rdata.from_sq;
              out_item_nxt.to_out    = ram_rdata.to_sq;
              if (depth_ok && bound_ok) begin
                out_item_nxt.hit       = 1'b1;
                out_item_nxt.score_out = ram_rdata.score;
              end
            end
          end
          REQ_STORE: begin
            if (!keep) begin
              ram_we               = 1'b1;
              ram_wdata.key        = req_r.pos_key;
              ram_wdata.score      = req_r.score_in;
              ram_wdata.to_sq      = req_r.to_in;
              ram_wdata.from_sq    = req_r.from_in;
              ram_wdata.gen        = gen_r;
              ram_wdata.flag       = req_r.bound_kind;
              ram_wdata.depth      = req_r.depth_left;
              out_item_nxt.written = 1'b1;
            end
          end
          REQ_NEWGEN: begin
            gen_nxt = gen_r + 8'd1;
          end
          default: begin
          end
        endcase
      end
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == {INDEX_BITS{1'b1}}) begin
          state_nxt      = ST_IDLE;
          out_valid_nxt  = clr_report_r;
          clr_report_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers; reset starts a silent clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      clr_report_r <= 1'b0;
      gen_r        <= 8'd0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      clr_report_r <= clr_report_nxt;
      gen_r        <= gen_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_item;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A result always lands while the block is free for the next item.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !busy)
    else $error("result strobed while busy");

  // Every lookup cycle yields exactly one result in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n) (state_r == ST_LOOKUP) |=> out_valid)
    else $error("lookup without result");

  // A non-clear item goes straight to lookup.
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.req_type != REQ_CLEAR) |=> (state_r == ST_LOOKUP))
    else $error("accepted item not looked up");

  // A score hit implies the key matched.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.hit) |-> out_item.key_match)
    else $error("hit without key match");

  // The memory is only written on a store or during a clearing pass.
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r == ST_CLEAR) ||
                (state_r == ST_LOOKUP && req_r.req_type == REQ_STORE)))
    else $error("unexpected slot write");

endmodule
